// File: rtl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types, mode codes and helpers for the layer blend compositor.
// ----------------------------------------------------------------------------
package lbc_pkg;

   localparam logic [3:0] MODE_NORMAL     = 4'd0;
   localparam logic [3:0] MODE_MULTIPLY   = 4'd1;
   localparam logic [3:0] MODE_ADD        = 4'd2;
   localparam logic [3:0] MODE_BURN       = 4'd3;
   localparam logic [3:0] MODE_DODGE      = 4'd4;
   localparam logic [3:0] MODE_REFLECT    = 4'd5;
   localparam logic [3:0] MODE_GLOW       = 4'd6;
   localparam logic [3:0] MODE_OVERLAY    = 4'd7;
   localparam logic [3:0] MODE_DIFFERENCE = 4'd8;
   localparam logic [3:0] MODE_NEGATION   = 4'd9;
   localparam logic [3:0] MODE_LIGHTEN    = 4'd10;
   localparam logic [3:0] MODE_DARKEN     = 4'd11;
   localparam logic [3:0] MODE_SCREEN     = 4'd12;
   localparam logic [3:0] MODE_XOR        = 4'd13;

   localparam logic [0:0] CSR_BLEND_MODE    = 1'b0;
   localparam logic [0:0] CSR_LAYER_OPACITY = 1'b1;

   localparam int NUM_STAGES = 22;
   localparam int LAST_STAGE = NUM_STAGES - 1;

   typedef enum logic [1:0] {
      KIND_FIXED,
      KIND_DIV255,
      KIND_DIVIDE
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] num;
      logic [7:0]  den;
      logic [7:0]  rem;
      logic [7:0]  quo;
      logic        ovf;
      logic [7:0]  mixed;
      logic [15:0] dst_weighted;
   } chan_type;

   typedef struct packed {
      logic           valid;
      logic           last;
      logic [31:0]    dst;
      logic [31:0]    src;
      logic [3:0]     mode;
      logic [7:0]     opacity;
      logic [15:0]    alpha_prod;
      logic [7:0]     sa;
      logic [7:0]     dw;
      logic [7:0]     oa;
      logic           pass_dst;
      logic           pass_src;
      chan_type [2:0] chan;
   } stage_type;

   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

   function automatic logic [7:0] sat255(input logic [8:0] x);
      return x[8] ? 8'hFF : x[7:0];
   endfunction

endpackage

// File: rtl/layer_blend_composite.sv
// ----------------------------------------------------------------------------
// layer_blend_composite
// Blends a source pixel onto a destination pixel and composites it over.
// ----------------------------------------------------------------------------
// The req channel carries one transaction per pixel pair: bottom_pixel in
// tdata bits 31:0, top_pixel in bits 63:32, and the image's last flag on
// tlast. The rsp channel returns one composited ARGB pixel per transaction
// with the last flag copied to tlast.
// The csr port sets the blend mode (index 0) and the layer opacity (index 1)
// and should only be written while no transaction is in flight.
// The pipeline has 22 register stages; while the receiver does not stall,
// one transaction is taken every cycle. The depth is set by two long
// dividers in series, the blend-mode divider and the final divide by the
// output alpha, each retiring one quotient bit per stage.
// When the receiver stalls, the whole pipeline holds and req_tready falls
// in the same cycle, so no transaction is lost or repeated.
// Reset empties the pipeline and sets mode normal and opacity 255.
// ----------------------------------------------------------------------------
module layer_blend_composite (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // bottom_pixel, top_pixel
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // blended_pixel
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import lbc_pkg::*;

   logic [3:0] mode_ff;
   logic [7:0] opacity_ff;
   stage_type  pipe_ff [NUM_STAGES];
   stage_type  pipe_in [NUM_STAGES];
   stage_type  entry;
   logic       advance;

   function automatic stage_type stage_fn(input stage_type s, input int k);
      stage_type r;
      logic [7:0] d, s8, nd, ns, q;
      logic [8:0] ma, tsum;
      logic [7:0] mb;
      logic [8:0] trial;
      int j;
      r = s;
      for (int c = 0; c < 3; c++) begin
         d  = s.dst[8*c +: 8];
         s8 = s.src[8*c +: 8];
         nd = 8'hFF - d;
         ns = 8'hFF - s8;
         ma = 9'd0;
         mb = 8'd0;
         tsum = {1'b0, d} + {1'b0, s8};
         if (k == 1) begin
            r.chan[c].kind  = KIND_FIXED;
            r.chan[c].den   = 8'd1;
            r.chan[c].mixed = s8;
            case (s.mode)
               MODE_MULTIPLY: begin
                  r.chan[c].kind = KIND_DIV255;
                  ma = {1'b0, d};
                  mb = s8;
               end
               MODE_ADD: r.chan[c].mixed = sat255(tsum);
               MODE_BURN: begin
                  if (s8 == 8'd0) begin
                     r.chan[c].mixed = 8'd0;
                  end else begin
                     r.chan[c].kind = KIND_DIVIDE;
                     ma = {1'b0, nd};
                     mb = 8'hFF;
                     r.chan[c].den = s8;
                  end
               end
               MODE_DODGE, MODE_REFLECT: begin
                  if (s8 == 8'hFF) begin
                     r.chan[c].mixed = 8'hFF;
                  end else begin
                     r.chan[c].kind = KIND_DIVIDE;
                     ma = {1'b0, d};
                     mb = (s.mode == MODE_DODGE) ? 8'hFF : d;
                     r.chan[c].den = ns;
                  end
               end
               MODE_GLOW: begin
                  if (d == 8'hFF) begin
                     r.chan[c].mixed = 8'hFF;
                  end else begin
                     r.chan[c].kind = KIND_DIVIDE;
                     ma = {1'b0, s8};
                     mb = s8;
                     r.chan[c].den = nd;
                  end
               end
               MODE_OVERLAY: begin
                  r.chan[c].kind = KIND_DIV255;
                  if (!d[7]) begin
                     ma = {d, 1'b0};
                     mb = s8;
                  end else begin
                     ma = {nd, 1'b0};
                     mb = ns;
                  end
               end
               MODE_DIFFERENCE: r.chan[c].mixed = (d > s8) ? d - s8 : s8 - d;
               MODE_NEGATION: begin
                  r.chan[c].mixed = tsum > 9'd255 ? 8'hFF - (tsum[7:0] + 8'd1)
                                                  : tsum[7:0];
               end
               MODE_LIGHTEN: r.chan[c].mixed = (d > s8) ? d : s8;
               MODE_DARKEN:  r.chan[c].mixed = (d < s8) ? d : s8;
               MODE_SCREEN: begin
                  r.chan[c].kind = KIND_DIV255;
                  ma = {1'b0, nd};
                  mb = ns;
               end
               MODE_XOR: r.chan[c].mixed = d ^ s8;
               default:  r.chan[c].mixed = s8;
            endcase
            r.chan[c].num = 16'({8'd0, ma} * {9'd0, mb});
         end else if (k == 2) begin
            q = div255(s.chan[c].num);
            if (s.chan[c].kind == KIND_DIV255) begin
               r.chan[c].kind = KIND_FIXED;
               if (s.mode == MODE_SCREEN || (s.mode == MODE_OVERLAY && d[7])) begin
                  r.chan[c].mixed = 8'hFF - q;
               end else begin
                  r.chan[c].mixed = q;
               end
            end
            r.chan[c].ovf = s.chan[c].num[15:8] >= s.chan[c].den;
            r.chan[c].rem = s.chan[c].num[15:8];
            r.chan[c].quo = 8'd0;
         end else if ((k >= 3 && k <= 10) || (k >= 13 && k <= 20)) begin
            j = (k <= 10) ? 10 - k : 20 - k;
            trial = {s.chan[c].rem, s.chan[c].num[j]};
            if (trial >= {1'b0, s.chan[c].den}) begin
               r.chan[c].rem = 8'(trial - {1'b0, s.chan[c].den});
               r.chan[c].quo = {s.chan[c].quo[6:0], 1'b1};
            end else begin
               r.chan[c].rem = trial[7:0];
               r.chan[c].quo = {s.chan[c].quo[6:0], 1'b0};
            end
         end else if (k == 11) begin
            if (s.chan[c].kind == KIND_DIVIDE) begin
               if (s.mode == MODE_BURN) begin
                  r.chan[c].mixed = (s.chan[c].ovf || s.chan[c].quo == 8'hFF) ? 8'd0
                                                                  : ~s.chan[c].quo;
               end else begin
                  r.chan[c].mixed = s.chan[c].ovf ? 8'hFF : s.chan[c].quo;
               end
            end
         end else if (k == 12) begin
            r.chan[c].num = {8'd0, s.chan[c].mixed} * {8'd0, s.sa}
                            + s.chan[c].dst_weighted;
            r.chan[c].den = s.oa;
            r.chan[c].rem = r.chan[c].num[15:8];
            r.chan[c].quo = 8'd0;
         end
         if (k == 5) begin
            r.chan[c].dst_weighted = {8'd0, d} * {8'd0, s.dw};
         end
      end
      if (k == 0) begin
         r.alpha_prod = {8'd0, s.src[31:24]} * {8'd0, s.opacity};
      end else if (k == 2) begin
         r.sa = div255(s.alpha_prod);
      end else if (k == 3) begin
         r.pass_dst   = (s.sa == 8'd0);
         r.pass_src   = (s.dst[31:24] == 8'd0);
         r.alpha_prod = {8'd0, s.dst[31:24]} * {8'd0, 8'hFF - s.sa};
      end else if (k == 4) begin
         r.dw = div255(s.alpha_prod);
      end else if (k == 5) begin
         r.oa = s.sa + s.dw;
      end
      return r;
   endfunction

   // The dw product is formed in stage 3 and divided in stage 4, so the
   // per-channel dst weighting uses dw in stage 5.
   always_comb begin
      entry          = '0;
      entry.valid    = req_tvalid;
      entry.last     = req_tlast;
      entry.dst      = req_tdata[31:0];
      entry.src      = req_tdata[63:32];
      entry.mode     = (mode_ff > MODE_XOR) ? MODE_NORMAL : mode_ff;
      entry.opacity  = opacity_ff;
      pipe_in[0]     = stage_fn(entry, 0);
      for (int k = 1; k < NUM_STAGES; k++) begin
         pipe_in[k] = stage_fn(pipe_ff[k-1], k);
      end
   end

   assign advance    = !pipe_ff[LAST_STAGE].valid || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_NORMAL;
         opacity_ff <= 8'hFF;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BLEND_MODE:    mode_ff    <= csr_wdata[3:0];
            CSR_LAYER_OPACITY: opacity_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            pipe_ff[k].valid <= 1'b0;
         end
      end else if (advance) begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   logic [31:0] result;
   always_comb begin
      if (pipe_ff[LAST_STAGE].pass_dst) begin
         result = pipe_ff[LAST_STAGE].dst;
      end else if (pipe_ff[LAST_STAGE].pass_src) begin
         result = {pipe_ff[LAST_STAGE].sa, pipe_ff[LAST_STAGE].src[23:0]};
      end else begin
         result = {pipe_ff[LAST_STAGE].oa, pipe_ff[LAST_STAGE].chan[2].quo,
                   pipe_ff[LAST_STAGE].chan[1].quo, pipe_ff[LAST_STAGE].chan[0].quo};
      end
   end

   assign rsp_tvalid = pipe_ff[LAST_STAGE].valid;
   assign rsp_tdata  = result;
   assign rsp_tlast  = pipe_ff[LAST_STAGE].last;

endmodule
